// File: design/flpq_pkg.sv
// flpq_pkg: shared types, codes and sizes of the four-level priority queue
`timescale 1ns / 1ps

package flpq_pkg;

  localparam int NUM_CLASSES       = 4;
  localparam int CLASS_W           = 2;
  localparam int TIME_W            = 11;
  localparam int WAIT_W            = 12;
  localparam int COUNT_W           = 16;
  localparam int PEAK_W            = 9;
  localparam int LEN_W             = 7;
  localparam int TICKET_OUT_W      = 16;
  localparam int QUEUE_DEPTH_DEF   = 64;
  localparam int TICKET_BITS_DEF   = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [PEAK_W-1:0]  PEAK_MAX  = {PEAK_W{1'b1}};

  localparam logic KIND_ARRIVE = 1'b0;
  localparam logic KIND_SERVE  = 1'b1;

  typedef enum logic [2:0] {
    ST_QUEUED  = 3'd0,
    ST_INVALID = 3'd1,
    ST_FULL    = 3'd2,
    ST_SERVED  = 3'd3,
    ST_EMPTY   = 3'd4
  } status_e;

  typedef struct packed {
    logic              kind;
    logic [2:0]        priority_class;
    logic [TIME_W-1:0] time_minutes;
  } flpq_in_t;

  typedef struct packed {
    logic [2:0]                status;
    logic [TICKET_OUT_W-1:0]   ticket;
    logic [CLASS_W-1:0]        served_class;
    logic signed [WAIT_W-1:0]  wait_minutes;
    logic [LEN_W-1:0]          len_emergency;
    logic [LEN_W-1:0]          len_urgent;
    logic [LEN_W-1:0]          len_less_urgent;
    logic [LEN_W-1:0]          len_non_urgent;
    logic [COUNT_W-1:0]        total_served;
    logic [COUNT_W-1:0]        served_in_class;
    logic [PEAK_W-1:0]         peak_occupancy;
    logic [TIME_W-1:0]         max_wait;
  } flpq_out_t;

  // controller to datapath
  typedef struct packed {
    logic step_now;    // arrival or serve with nothing waiting, result this beat
    logic pop_start;   // serve accepted, head entry read issued
    logic pop_finish;  // head entry read back, pointers and stats updated
  } flpq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic all_empty;
  } flpq_stat_t;

endpackage

// File: design/flpq_chan_if.sv
// flpq_chan_if: valid/ready channel carrying one payload per beat
`timescale 1ns / 1ps

interface flpq_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/flpq_ctrl.sv
// flpq_ctrl: handshake and sequencing state machine of the priority queue
`timescale 1ns / 1ps

module flpq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_kind_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  flpq_pkg::flpq_stat_t stat_i,
  output flpq_pkg::flpq_cmd_t  cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_POP  = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;
  logic accept;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.step_now   = accept && ((in_kind_i == flpq_pkg::KIND_ARRIVE) || stat_i.all_empty);
    cmd_o.pop_start  = accept && (in_kind_i == flpq_pkg::KIND_SERVE) && !stat_i.all_empty;
    cmd_o.pop_finish = (state_q == S_POP);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.pop_start) state_d = S_POP;
      end
      S_POP: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd_o.step_now || cmd_o.pop_finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: design/flpq_dp.sv
// flpq_dp: entry memory, queue pointers, statistics and result register
`timescale 1ns / 1ps

module flpq_dp #(
  parameter int QUEUE_DEPTH = flpq_pkg::QUEUE_DEPTH_DEF,
  parameter int TICKET_BITS = flpq_pkg::TICKET_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  flpq_pkg::flpq_cmd_t  cmd_i,
  input  flpq_pkg::flpq_in_t   in_i,
  output flpq_pkg::flpq_stat_t stat_o,
  output flpq_pkg::flpq_out_t  out_o
);

  localparam int NCLS   = flpq_pkg::NUM_CLASSES;
  localparam int CLS_W  = flpq_pkg::CLASS_W;
  localparam int TIME_W = flpq_pkg::TIME_W;
  localparam int WAIT_W = flpq_pkg::WAIT_W;
  localparam int CW     = flpq_pkg::COUNT_W;
  localparam int PW     = flpq_pkg::PEAK_W;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int SUM_W  = CNT_W + 1;
  localparam int TOT_W  = CNT_W + 2;
  localparam int MEM_D  = NCLS * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(MEM_D);
  localparam int ENT_W  = TICKET_BITS + TIME_W;

  logic [ENT_W-1:0] mem_q [MEM_D];
  logic [ENT_W-1:0] rd_q;

  logic [IDX_W-1:0]       head_q [NCLS];
  logic [IDX_W-1:0]       head_d [NCLS];
  logic [CNT_W-1:0]       count_q [NCLS];
  logic [CNT_W-1:0]       count_d [NCLS];
  logic [CW-1:0]          cls_served_q [NCLS];
  logic [CW-1:0]          cls_served_d [NCLS];
  logic [TICKET_BITS-1:0] ticket_q, ticket_d;
  logic [CW-1:0]          all_served_q, all_served_d;
  logic [PW-1:0]          peak_q, peak_d;
  logic [TIME_W-1:0]      longest_q, longest_d;
  logic [CLS_W-1:0]       pick_q;
  logic [TIME_W-1:0]      now_q;
  flpq_pkg::flpq_out_t    out_q, out_d;

  logic [CLS_W-1:0]       arr_cls;
  logic                   cls_ok;
  logic                   full;
  logic [SUM_W-1:0]       pos_sum;
  logic [IDX_W-1:0]       wr_pos;
  logic [ADDR_W-1:0]      wr_addr;
  logic                   mem_we;
  logic [CLS_W-1:0]       pick;
  logic [ADDR_W-1:0]      rd_addr;
  logic [TOT_W-1:0]       total;
  logic [TIME_W-1:0]      ent_when;
  logic [TICKET_BITS-1:0] ent_tick;
  logic signed [WAIT_W-1:0] wait_val;

  // arrival slot address
  always_comb begin
    arr_cls = in_i.priority_class[CLS_W-1:0];
    cls_ok  = (in_i.priority_class[2] == 1'b0);
    full    = (count_q[arr_cls] >= CNT_W'(QUEUE_DEPTH));
    pos_sum = SUM_W'(head_q[arr_cls]) + SUM_W'(count_q[arr_cls]);
    if (pos_sum >= SUM_W'(QUEUE_DEPTH)) begin
      wr_pos = IDX_W'(pos_sum - SUM_W'(QUEUE_DEPTH));
    end else begin
      wr_pos = IDX_W'(pos_sum);
    end
    wr_addr = ADDR_W'(arr_cls) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(wr_pos);
    mem_we  = cmd_i.step_now && (in_i.kind == flpq_pkg::KIND_ARRIVE) && cls_ok && !full;
  end

  // most urgent non-empty class
  always_comb begin
    pick = CLS_W'(NCLS - 1);
    for (int c = NCLS - 1; c >= 0; c--) begin
      if (count_q[c] != '0) pick = CLS_W'(c);
    end
    stat_o.all_empty = (count_q[0] == '0) && (count_q[1] == '0) &&
                       (count_q[2] == '0) && (count_q[3] == '0);
    rd_addr = ADDR_W'(pick) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_q[pick]);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[wr_addr] <= {ticket_q, in_i.time_minutes};
    if (cmd_i.pop_start) rd_q <= mem_q[rd_addr];
  end

  always_comb begin
    ent_tick = rd_q[ENT_W-1:TIME_W];
    ent_when = rd_q[TIME_W-1:0];
    wait_val = $signed({1'b0, now_q}) - $signed({1'b0, ent_when});
  end

  always_comb begin
    head_d       = head_q;
    count_d      = count_q;
    cls_served_d = cls_served_q;
    ticket_d     = ticket_q;
    all_served_d = all_served_q;
    peak_d       = peak_q;
    longest_d    = longest_q;
    out_d        = out_q;
    total        = '0;

    if (cmd_i.step_now && (in_i.kind == flpq_pkg::KIND_ARRIVE)) begin
      ticket_d = ticket_q + 1'b1;
      if (mem_we) count_d[arr_cls] = count_q[arr_cls] + 1'b1;
    end

    if (cmd_i.pop_finish) begin
      count_d[pick_q] = count_q[pick_q] - 1'b1;
      if (head_q[pick_q] == IDX_W'(QUEUE_DEPTH - 1)) begin
        head_d[pick_q] = '0;
      end else begin
        head_d[pick_q] = head_q[pick_q] + 1'b1;
      end
      if (cls_served_q[pick_q] != flpq_pkg::COUNT_MAX) begin
        cls_served_d[pick_q] = cls_served_q[pick_q] + 1'b1;
      end
      if (all_served_q != flpq_pkg::COUNT_MAX) all_served_d = all_served_q + 1'b1;
      // a negative wait never wins against a non-negative maximum
      if (wait_val > $signed({1'b0, longest_q})) longest_d = wait_val[TIME_W-1:0];
    end

    for (int c = 0; c < NCLS; c++) total = total + TOT_W'(count_d[c]);

    if (cmd_i.step_now && (in_i.kind == flpq_pkg::KIND_ARRIVE)) begin
      if (total > TOT_W'(flpq_pkg::PEAK_MAX)) begin
        if (flpq_pkg::PEAK_MAX > peak_q) peak_d = flpq_pkg::PEAK_MAX;
      end else if (PW'(total) > peak_q) begin
        peak_d = PW'(total);
      end
    end

    if (cmd_i.step_now || cmd_i.pop_finish) begin
      out_d.len_emergency   = flpq_pkg::LEN_W'(count_d[0]);
      out_d.len_urgent      = flpq_pkg::LEN_W'(count_d[1]);
      out_d.len_less_urgent = flpq_pkg::LEN_W'(count_d[2]);
      out_d.len_non_urgent  = flpq_pkg::LEN_W'(count_d[3]);
      out_d.total_served    = all_served_d;
      out_d.peak_occupancy  = peak_d;
      out_d.max_wait        = longest_d;
      out_d.ticket          = '0;
      out_d.served_class    = '0;
      out_d.wait_minutes    = '0;
      out_d.served_in_class = '0;
      if (cmd_i.pop_finish) begin
        out_d.status          = flpq_pkg::ST_SERVED;
        out_d.ticket          = flpq_pkg::TICKET_OUT_W'(ent_tick);
        out_d.served_class    = pick_q;
        out_d.wait_minutes    = wait_val;
        out_d.served_in_class = cls_served_d[pick_q];
      end else if (in_i.kind == flpq_pkg::KIND_ARRIVE) begin
        out_d.ticket = flpq_pkg::TICKET_OUT_W'(ticket_q);
        priority if (!cls_ok) begin
          out_d.status = flpq_pkg::ST_INVALID;
        end else if (full) begin
          out_d.status = flpq_pkg::ST_FULL;
        end else begin
          out_d.status = flpq_pkg::ST_QUEUED;
        end
      end else begin
        out_d.status = flpq_pkg::ST_EMPTY;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NCLS; c++) begin
        head_q[c]       <= '0;
        count_q[c]      <= '0;
        cls_served_q[c] <= '0;
      end
      ticket_q     <= TICKET_BITS'(1);
      all_served_q <= '0;
      peak_q       <= '0;
      longest_q    <= '0;
    end else begin
      head_q       <= head_d;
      count_q      <= count_d;
      cls_served_q <= cls_served_d;
      ticket_q     <= ticket_d;
      all_served_q <= all_served_d;
      peak_q       <= peak_d;
      longest_q    <= longest_d;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (cmd_i.pop_start) begin
      pick_q <= pick;
      now_q  <= in_i.time_minutes;
    end
  end

  assign out_o = out_q;

endmodule

// File: design/four_level_priority_queue_unit.sv
// four_level_priority_queue_unit: top level of the four-class priority queue
//
// usage: in_i carries one request per beat (arrival with class and time, or a
// serve request with its time); out_o carries exactly one result per request,
// in request order, valid/ready on both sides.
// an arrival's result is registered at the accept edge and shows on out_o in
// the next cycle.
// a serve with a non-empty queue reads the head entry from the entry memory
// when it is accepted, then updates pointers and counts and registers the
// result in S_POP; a serve with all queues empty completes like an arrival.
// sustained throughput: 1 request per cycle for arrivals while out_o does not
// stall; a serve holds off the next request during S_POP, limited by the
// registered memory read.
// the result register lets a new request in during the beat in which the
// previous result is taken; while out_o stalls, in_i.ready stays low.
// reset clears pointers, counts and statistics at once and sets the ticket
// counter to one; the entry memory is not cleared, no sweep is needed.
`timescale 1ns / 1ps

module four_level_priority_queue_unit #(
  parameter int QUEUE_DEPTH = flpq_pkg::QUEUE_DEPTH_DEF,
  parameter int TICKET_BITS = flpq_pkg::TICKET_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  flpq_chan_if.sink    in_i,
  flpq_chan_if.source  out_o
);

  flpq_pkg::flpq_cmd_t  cmd;
  flpq_pkg::flpq_stat_t stat;
  flpq_pkg::flpq_in_t   in_data;
  flpq_pkg::flpq_out_t  out_data;

  assign in_data    = in_i.data;
  assign out_o.data = out_data;

  flpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_kind_i   (in_data.kind),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  flpq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TICKET_BITS (TICKET_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .in_i   (in_data),
    .stat_o (stat),
    .out_o  (out_data)
  );

  // a new request is taken only when the result register is free this beat
  a_ready_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (!out_o.valid || out_o.ready))
    else $error("request taken while result register blocked");

  // a serve that reads memory holds off the next request in S_POP, then shows its result
  a_pop_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop_start |=> (!in_i.ready && out_o.valid == 1'b0) ##1 out_o.valid)
    else $error("serve sequencing broken");

  // an accepted arrival has its result on the next cycle
  a_arrival_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_data.kind == flpq_pkg::KIND_ARRIVE) |=> out_o.valid)
    else $error("arrival result missing");

  // a served result always carries non-zero served counts
  a_served_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_data.status == flpq_pkg::ST_SERVED) |->
      (out_data.served_in_class != '0 && out_data.total_served != '0))
    else $error("served result with zero counts");

endmodule
